// File: design/tlbpt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TLB page translator package
// Default sizes and fixed field widths of the LRU TLB page translator.
// ----------------------------------------------------------------------------
package tlbpt_pkg;

  // Fixed widths of the address fields.
  localparam int VA_W = 16;
  localparam int PA_W = 16;

  // Default configuration.
  localparam int TLB_ENTRIES_DEF = 16;
  localparam int OFFSET_BITS_DEF = 8;
  localparam int PAGE_COUNT_DEF  = 256;

endpackage

// File: design/tlb_lru_page_translator_core.sv
`timescale 1ns / 1ps
// Flow: an accepted address passes the page number reduction steps (0 at the defaults), a
//   search over the TLB ring, a page table fill on a miss only, and the output register.
// Only one address is in flight: a new one is accepted once the last result has moved into
//   the output register. The single comparator visits the TLB ring one slot per cycle.
// Reset: after rst_ni rises the page table is cleared one entry a cycle, all PAGE_COUNT entries,
//   during which no address is accepted.
// ----------------------------------------------------------------------------
// LRU TLB page translator
// Fully associative TLB kept as a rotating ring in recency order, searched by
// one comparator, backed by a demand-filled page table memory.
// ----------------------------------------------------------------------------
module tlb_lru_page_translator_core #(
  parameter int TLB_ENTRIES = tlbpt_pkg::TLB_ENTRIES_DEF,
  parameter int OFFSET_BITS = tlbpt_pkg::OFFSET_BITS_DEF,
  parameter int PAGE_COUNT  = tlbpt_pkg::PAGE_COUNT_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [tlbpt_pkg::VA_W-1:0] virtual_address_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [tlbpt_pkg::PA_W-1:0] physical_address_o,
  output logic                       tlb_hit_o,
  output logic                       page_fault_o
);
  import tlbpt_pkg::*;

  localparam int PG_W      = $clog2(PAGE_COUNT);
  localparam int NFF_W     = $clog2(PAGE_COUNT + 1);
  localparam int VPN_W     = (VA_W - OFFSET_BITS > 0) ? (VA_W - OFFSET_BITS) : 1;
  localparam int RED_STEPS = $clog2(((2 ** VPN_W) + PAGE_COUNT - 1) / PAGE_COUNT);
  localparam int RC_W      = (RED_STEPS > 1) ? $clog2(RED_STEPS) : 1;
  localparam int CMP_W     = VPN_W + PG_W;
  localparam int IDX_W     = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int PAF_W     = PG_W + OFFSET_BITS;

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_REDUCE = 3'd2;
  localparam logic [2:0] S_SEARCH = 3'd3;
  localparam logic [2:0] S_FILL   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  typedef struct packed {
    logic [PG_W-1:0] page;
    logic [PG_W-1:0] frame;
  } tlb_entry_t;

  typedef struct packed {
    logic            valid;
    logic [PG_W-1:0] frame;
  } pte_t;

  // Control state.
  logic [2:0]             state_q, state_d;
  logic [PG_W-1:0]        clr_q, clr_d;
  logic [RC_W-1:0]        red_cnt_q, red_cnt_d;
  logic [IDX_W-1:0]       s_cnt_q, s_cnt_d;
  logic [NFF_W-1:0]       nff_q, nff_d;
  logic                   out_valid_q, out_valid_d;
  logic [TLB_ENTRIES-1:0] tlb_vld_q, tlb_vld_nxt;

  // Item payload.
  logic [VPN_W-1:0]       pg_q, pg_d;
  logic [OFFSET_BITS-1:0] off_q, off_d;
  logic [PG_W-1:0]        fr_q, fr_d;
  logic                   hit_q, hit_d;
  logic                   fault_q, fault_d;
  logic [PA_W-1:0]        pa_q, pa_d;
  logic                   out_hit_q, out_hit_d;
  logic                   out_fault_q, out_fault_d;

  // TLB ring, slot 0 least recent.
  tlb_entry_t             tlb_q   [TLB_ENTRIES];
  tlb_entry_t             tlb_nxt [TLB_ENTRIES];
  logic                   tlb_mv, tlb_hold, tlb_ins;
  tlb_entry_t             ins_entry;

  // Page table memory.
  pte_t                   pt_mem [PAGE_COUNT];
  pte_t                   pt_rdata_q;
  logic                   pt_we;
  logic [PG_W-1:0]        pt_waddr;
  pte_t                   pt_wdata;

  logic [VA_W-1:0]        va_shifted;
  logic [PG_W-1:0]        pg_idx;
  logic [CMP_W-1:0]       pg_ext, sub_val;
  logic                   match;
  logic [PAF_W-1:0]       pa_full;

  assign va_shifted = virtual_address_i >> OFFSET_BITS;
  assign pg_idx     = PG_W'(pg_q);
  assign pg_ext     = CMP_W'(pg_q);
  assign sub_val    = CMP_W'(PAGE_COUNT) << red_cnt_q;
  assign match      = tlb_vld_q[0] && (tlb_q[0].page == pg_idx) && !hit_q;
  assign pa_full    = {fr_q, off_q};

  assign in_ready_o         = (state_q == S_IDLE);
  assign out_valid_o        = out_valid_q;
  assign physical_address_o = pa_q;
  assign tlb_hit_o          = out_hit_q;
  assign page_fault_o       = out_fault_q;

  // Ring movement: a plain step rotates slot 0 to the top. Once the hit entry
  // has reached the top it stays there while the lower slots finish rotating,
  // which leaves the hit entry most recent and the rest in their old order.
  for (genvar k = 0; k < TLB_ENTRIES; k++) begin : g_slot
    if (k == TLB_ENTRIES - 1) begin : g_top
      assign tlb_nxt[k]     = tlb_ins ? ins_entry : (tlb_hold ? tlb_q[k] : tlb_q[0]);
      assign tlb_vld_nxt[k] = tlb_ins ? 1'b1 : (tlb_hold ? tlb_vld_q[k] : tlb_vld_q[0]);
    end else if (k == TLB_ENTRIES - 2) begin : g_below
      assign tlb_nxt[k]     = tlb_hold ? tlb_q[0] : tlb_q[k+1];
      assign tlb_vld_nxt[k] = tlb_hold ? tlb_vld_q[0] : tlb_vld_q[k+1];
    end else begin : g_low
      assign tlb_nxt[k]     = tlb_q[k+1];
      assign tlb_vld_nxt[k] = tlb_vld_q[k+1];
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    red_cnt_d   = red_cnt_q;
    s_cnt_d     = s_cnt_q;
    nff_d       = nff_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    pg_d        = pg_q;
    off_d       = off_q;
    fr_d        = fr_q;
    hit_d       = hit_q;
    fault_d     = fault_q;
    pa_d        = pa_q;
    out_hit_d   = out_hit_q;
    out_fault_d = out_fault_q;
    tlb_mv      = 1'b0;
    tlb_hold    = 1'b0;
    tlb_ins     = 1'b0;
    ins_entry   = '{page: pg_idx, frame: fr_q};
    pt_we       = 1'b0;
    pt_waddr    = pg_idx;
    pt_wdata    = '{valid: 1'b1, frame: nff_q[PG_W-1:0]};

    case (state_q)
      S_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_q;
        pt_wdata = '0;
        if (clr_q == PG_W'(PAGE_COUNT - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          off_d   = virtual_address_i[OFFSET_BITS-1:0];
          pg_d    = VPN_W'(va_shifted);
          hit_d   = 1'b0;
          fault_d = 1'b0;
          s_cnt_d = '0;
          if (RED_STEPS > 0) begin
            red_cnt_d = RC_W'(RED_STEPS - 1);
            state_d   = S_REDUCE;
          end else begin
            state_d = S_SEARCH;
          end
        end
      end
      S_REDUCE: begin
        // Restoring reduction of the page number modulo the table size.
        if (pg_ext >= sub_val) begin
          pg_d = VPN_W'(pg_ext - sub_val);
        end
        if (red_cnt_q == '0) begin
          state_d = S_SEARCH;
        end else begin
          red_cnt_d = red_cnt_q - 1'b1;
        end
      end
      S_SEARCH: begin
        tlb_mv   = 1'b1;
        tlb_hold = hit_q;
        if (match) begin
          hit_d = 1'b1;
          fr_d  = tlb_q[0].frame;
        end
        if (s_cnt_q == IDX_W'(TLB_ENTRIES - 1)) begin
          state_d = (hit_q || match) ? S_DONE : S_FILL;
        end else begin
          s_cnt_d = s_cnt_q + 1'b1;
        end
      end
      S_FILL: begin
        tlb_mv  = 1'b1;
        tlb_ins = 1'b1;
        if (pt_rdata_q.valid) begin
          fr_d = pt_rdata_q.frame;
        end else begin
          fr_d    = nff_q[PG_W-1:0];
          fault_d = 1'b1;
          pt_we   = 1'b1;
          nff_d   = nff_q + 1'b1;
        end
        ins_entry = '{page: pg_idx, frame: fr_d};
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          pa_d        = PA_W'(pa_full);
          out_hit_d   = hit_q;
          out_fault_d = fault_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      red_cnt_q   <= '0;
      s_cnt_q     <= '0;
      nff_q       <= '0;
      out_valid_q <= 1'b0;
      tlb_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      red_cnt_q   <= red_cnt_d;
      s_cnt_q     <= s_cnt_d;
      nff_q       <= nff_d;
      out_valid_q <= out_valid_d;
      if (tlb_mv) begin
        tlb_vld_q <= tlb_vld_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pg_q        <= pg_d;
    off_q       <= off_d;
    fr_q        <= fr_d;
    hit_q       <= hit_d;
    fault_q     <= fault_d;
    pa_q        <= pa_d;
    out_hit_q   <= out_hit_d;
    out_fault_q <= out_fault_d;
    if (tlb_mv) begin
      tlb_q <= tlb_nxt;
    end
  end

  // The read address follows the current page, so the entry is ready by the
  // time the search over the ring has finished.
  always_ff @(posedge clk_i) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    pt_rdata_q <= pt_mem[pg_idx];
  end

`ifndef NO_ASSERTIONS
  a_ready_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after an accepted beat");

  a_hit_no_fault: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tlb_hit_o |-> !page_fault_o)
    else $error("result flags both a TLB hit and a page fault");

  a_fault_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL && !pt_rdata_q.valid |=> nff_q == $past(nff_q) + 1'b1)
    else $error("free frame counter did not advance on a page fault");

  a_frame_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nff_q <= NFF_W'(PAGE_COUNT))
    else $error("free frame counter ran past the page count");

  a_fill_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FILL |=> tlb_vld_q[TLB_ENTRIES-1])
    else $error("most recent TLB slot invalid after a fill");

  a_valid_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(tlb_vld_q) >= $countones($past(tlb_vld_q)))
    else $error("number of valid TLB entries decreased");
`endif

endmodule
